>>> rtl/ntcbt_pkg.sv
package ntcbt_pkg;

  // Converter and field widths
  localparam int ADC_BITS   = 12;
  localparam int ADC_W      = 12;
  localparam int TEMP_W     = 14;
  localparam int CODE_CMP_W = ADC_W + ADC_BITS;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int BETA_W     = 14;
  localparam int RES_W      = 24;
  localparam int T0_W       = 16;

  localparam logic [BETA_W-1:0] BETA_RST = 14'd3892;
  localparam logic [RES_W-1:0]  RN_RST   = 24'd100000;
  localparam logic [RES_W-1:0]  RS_RST   = 24'd100000;
  localparam logic [T0_W-1:0]   T0_RST   = 16'd29815;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BETA = 2'd0,
    CFG_RN   = 2'd1,
    CFG_RS   = 2'd2,
    CFG_T0   = 2'd3
  } cfg_idx_t;

  // log2 unit: Q.28 result, Q1.30 mantissa
  localparam int LOG_LANES  = 4;
  localparam int LOG_IN_W   = 24;
  localparam int LOG_FRAC   = 28;
  localparam int LOG_INT_W  = 5;
  localparam int LOG_W      = LOG_INT_W + LOG_FRAC;
  localparam int MANT_W     = 31;
  localparam int LOG_STAGES = LOG_FRAC + 1;

  // ln scaling
  localparam int SUM_W  = LOG_W + 1;
  localparam int LN2_W  = 28;
  localparam int LN2_FRAC = 28;
  localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065279;
  localparam int MUL_LO = 32;
  localparam int PROD_W = SUM_W + LN2_W;

  // Dividers
  localparam int DIV_W      = 64;
  localparam int DIV_STAGES = DIV_W;
  localparam int TERM_SH    = 20;
  localparam int T0_NUM     = 100;
  localparam int T0_SH      = 48;
  localparam int FIN_NUM    = 10;
  localparam int FIN_SH     = 56;
  localparam int INV_W      = 57;

  // Output conversion
  localparam int V_W        = 62;
  localparam int OFFSET_Q8  = 699264;
  localparam int Q8_SH      = 8;
  localparam int OUT_HI_MAG = 6000;
  localparam int OUT_LO_MAG = 1000;
  localparam logic signed [TEMP_W-1:0] OUT_MAX = 14'sd6000;
  localparam logic signed [TEMP_W-1:0] OUT_MIN = -14'sd1000;

endpackage

>>> rtl/ntcbt_in_if.sv
interface ntcbt_in_if;
  import ntcbt_pkg::*;

  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

>>> rtl/ntcbt_out_if.sv
interface ntcbt_out_if;
  import ntcbt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_tenths_c;

  modport source (output valid, output temp_tenths_c, input ready);
  modport sink   (input valid, input temp_tenths_c, output ready);
endinterface

>>> rtl/ntcbt_log2.sv
module ntcbt_log2 (
  input  logic clk,
  input  logic en,
  input  logic [ntcbt_pkg::LOG_LANES-1:0][ntcbt_pkg::LOG_IN_W-1:0] x,
  output logic [ntcbt_pkg::LOG_LANES-1:0][ntcbt_pkg::LOG_W-1:0]    lg
);
  import ntcbt_pkg::*;

  logic [MANT_W-1:0]    m_r    [LOG_LANES][LOG_FRAC+1];
  logic [LOG_FRAC-1:0]  frac_r [LOG_LANES][LOG_FRAC+1];
  logic [LOG_INT_W-1:0] p_r    [LOG_LANES][LOG_FRAC+1];

  for (genvar ln = 0; ln < LOG_LANES; ln++) begin : g_lane
    logic [LOG_INT_W-1:0] p_nxt;
    logic [MANT_W-1:0]    m_nxt;

    // leading one, then normalize to Q1.30
    always_comb begin
      p_nxt = '0;
      for (int i = 0; i < LOG_IN_W; i++) begin
        if (x[ln][i]) p_nxt = LOG_INT_W'(i);
      end
      m_nxt = MANT_W'(x[ln]) << (LOG_INT_W'(MANT_W - 1) - p_nxt);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[ln][0]    <= m_nxt;
        frac_r[ln][0] <= '0;
        p_r[ln][0]    <= p_nxt;
      end
    end

    // one fraction bit per stage by squaring
    for (genvar st = 0; st < LOG_FRAC; st++) begin : g_step
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     top;

      assign sq  = {{MANT_W{1'b0}}, m_r[ln][st]} * {{MANT_W{1'b0}}, m_r[ln][st]};
      assign top = sq[2*MANT_W-1:MANT_W-1];

      always_ff @(posedge clk) begin
        if (en) begin
          if (top[MANT_W]) begin
            m_r[ln][st+1] <= top[MANT_W:1];
          end else begin
            m_r[ln][st+1] <= top[MANT_W-1:0];
          end
          frac_r[ln][st+1] <= {frac_r[ln][st][LOG_FRAC-2:0], top[MANT_W]};
          p_r[ln][st+1]    <= p_r[ln][st];
        end
      end
    end

    assign lg[ln] = {p_r[ln][LOG_FRAC], frac_r[ln][LOG_FRAC]};
  end

endmodule

>>> rtl/ntcbt_div.sv
module ntcbt_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ntcbt_pkg::DIV_W-1:0] num,
  input  logic [ntcbt_pkg::DIV_W-1:0] den,
  output logic [ntcbt_pkg::DIV_W-1:0] quo
);
  import ntcbt_pkg::*;

  logic [DIV_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_W-1:0] num_r [DIV_STAGES];
  logic [DIV_W-1:0] q_r   [DIV_STAGES];
  logic [DIV_W-1:0] den_r [DIV_STAGES];

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_W-1:0] rem_in, num_in, q_in, den_in;
    logic [DIV_W:0]   t;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign q_in   = q_r[s-1];
      assign den_in = den_r[s-1];
    end

    assign t  = {rem_in, num_in[DIV_W-1]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? DIV_W'(t - {1'b0, den_in}) : t[DIV_W-1:0];
        num_r[s] <= num_in << 1;
        q_r[s]   <= {q_in[DIV_W-2:0], ge};
        den_r[s] <= den_in;
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

>>> rtl/ntc_beta_temperature.sv
// NTC thermistor temperature by the beta equation, fixed point, fully pipelined.
// Pipeline from input accept to out_chan.valid: input register, 29-stage log2
//   squaring chain, 4 combine/scale stages, two 64-stage bit-per-stage dividers
//   in series with a sum stage between, one conversion stage, output register.
// Throughput: one request per cycle; the pipeline stalls only when the output
//   register holds an untaken result and the last stage carries a request.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads default config.
module ntc_beta_temperature (
  input  logic                             clk,
  input  logic                             rst_n,
  ntcbt_in_if.sink                         in_chan,
  ntcbt_out_if.source                      out_chan,
  input  logic                             cfg_we,
  input  logic [ntcbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntcbt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ntcbt_pkg::*;

  // Valid chain positions of each pipeline register group
  localparam int ST_CODE  = 0;
  localparam int ST_LOG   = ST_CODE + LOG_STAGES;
  localparam int ST_SUM   = ST_LOG + 1;
  localparam int ST_MAG   = ST_SUM + 1;
  localparam int ST_MUL   = ST_MAG + 1;
  localparam int ST_LN    = ST_MUL + 1;
  localparam int ST_DIV1  = ST_LN + DIV_STAGES;
  localparam int ST_INV   = ST_DIV1 + 1;
  localparam int ST_DIV2  = ST_INV + DIV_STAGES;
  localparam int ST_POST  = ST_DIV2 + 1;
  localparam int PIPE_LAT = ST_POST + 1;

  localparam logic [CODE_CMP_W-1:0] FS_CMP = CODE_CMP_W'(1) << ADC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [BETA_W-1:0] beta_r;
  logic [RES_W-1:0]  rn_r;
  logic [RES_W-1:0]  rs_r;
  logic [T0_W-1:0]   t0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= BETA_RST;
      rn_r   <= RN_RST;
      rs_r   <= RS_RST;
      t0_r   <= T0_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BETA: beta_r <= cfg_wdata[BETA_W-1:0];
        CFG_RN:   rn_r   <= cfg_wdata[RES_W-1:0];
        CFG_RS:   rs_r   <= cfg_wdata[RES_W-1:0];
        CFG_T0:   t0_r   <= cfg_wdata[T0_W-1:0];
        default: ;
      endcase
    end
  end

  // zero register values act as one
  logic [RES_W-1:0]  rn_eff, rs_eff;
  logic [BETA_W-1:0] beta_eff;
  logic [T0_W-1:0]   t0_eff;

  assign rn_eff   = (rn_r == '0)   ? RES_W'(1)  : rn_r;
  assign rs_eff   = (rs_r == '0)   ? RES_W'(1)  : rs_r;
  assign beta_eff = (beta_r == '0) ? BETA_W'(1) : beta_r;
  assign t0_eff   = (t0_r == '0)   ? T0_W'(1)   : t0_r;

  // ---------------------------------------------------------------------------
  // Flow control. The output register loads when empty or taken; the pipe
  // advances then, or whenever its last stage is a bubble, so bubbles squeeze
  // out while a result waits.
  // ---------------------------------------------------------------------------
  logic [PIPE_LAT-1:0] vld_r;
  logic                out_valid_r;
  logic                v_last, out_en, adv, fire;

  assign v_last = vld_r[PIPE_LAT-1];
  assign out_en = !out_valid_r || out_chan.ready;
  assign adv    = out_en || !v_last;
  assign fire   = in_chan.valid && adv;

  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) vld_r <= {vld_r[PIPE_LAT-2:0], fire};
      if (out_en) out_valid_r <= v_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: clamp the code into 1 .. full scale - 1
  // ---------------------------------------------------------------------------
  logic [ADC_BITS-1:0] code_nxt, code_r;

  always_comb begin
    if (in_chan.adc_code == '0) begin
      code_nxt = ADC_BITS'(1);
    end else if (CODE_CMP_W'(in_chan.adc_code) >= FS_CMP) begin
      code_nxt = '1;
    end else begin
      code_nxt = ADC_BITS'(in_chan.adc_code);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) code_r <= code_nxt;
  end

  // ---------------------------------------------------------------------------
  // Four log2 lanes in lockstep: FS - code, Rs, code, Rn
  // ---------------------------------------------------------------------------
  logic [LOG_LANES-1:0][LOG_IN_W-1:0] log_x;
  logic [LOG_LANES-1:0][LOG_W-1:0]    log_y;
  logic [ADC_BITS:0]                  fs_minus;

  assign fs_minus = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, code_r};
  assign log_x[0] = LOG_IN_W'(fs_minus);
  assign log_x[1] = LOG_IN_W'(rs_eff);
  assign log_x[2] = LOG_IN_W'(code_r);
  assign log_x[3] = LOG_IN_W'(rn_eff);

  ntcbt_log2 u_log2 (
    .clk (clk),
    .en  (adv),
    .x   (log_x),
    .lg  (log_y)
  );

  // ---------------------------------------------------------------------------
  // Combine: log2 of R/Rn as sign and magnitude, then scale by ln2
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]          pos_r, neg_r, mag_r;
  logic                      lneg_mag_r, lneg_mul_r, lneg_ln_r;
  logic [MUL_LO+LN2_W-1:0]   plo_r;
  logic [SUM_W-MUL_LO+LN2_W-1:0] phi_r;
  logic [PROD_W-1:0]         prod;
  logic [SUM_W-1:0]          lnmag_r;

  assign prod = PROD_W'(plo_r) + (PROD_W'(phi_r) << MUL_LO);

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_r <= SUM_W'(log_y[0]) + SUM_W'(log_y[1]);
      neg_r <= SUM_W'(log_y[2]) + SUM_W'(log_y[3]);

      lneg_mag_r <= neg_r > pos_r;
      mag_r      <= (neg_r > pos_r) ? neg_r - pos_r : pos_r - neg_r;

      // split product: low 32 bits and the high two bits of the magnitude
      plo_r      <= (MUL_LO+LN2_W)'(mag_r[MUL_LO-1:0]) * (MUL_LO+LN2_W)'(LN2_Q28);
      phi_r      <= (SUM_W-MUL_LO+LN2_W)'(mag_r[SUM_W-1:MUL_LO])
                    * (SUM_W-MUL_LO+LN2_W)'(LN2_Q28);
      lneg_mul_r <= lneg_mag_r;

      lnmag_r    <= prod[PROD_W-1:LN2_FRAC];
      lneg_ln_r  <= lneg_mul_r;
    end
  end

  // ---------------------------------------------------------------------------
  // ln/B and 1/T0 side by side, both Q.48
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]      term_q, inv0_q;
  logic [DIV_STAGES-1:0] lneg_sh_r;

  ntcbt_div u_div_term (
    .clk (clk),
    .en  (adv),
    .num (DIV_W'(lnmag_r) << TERM_SH),
    .den (DIV_W'(beta_eff)),
    .quo (term_q)
  );

  ntcbt_div u_div_t0 (
    .clk (clk),
    .en  (adv),
    .num (DIV_W'(T0_NUM) << T0_SH),
    .den (DIV_W'(t0_eff)),
    .quo (inv0_q)
  );

  always_ff @(posedge clk) begin
    if (adv) lneg_sh_r <= {lneg_sh_r[DIV_STAGES-2:0], lneg_ln_r};
  end

  // ---------------------------------------------------------------------------
  // Reciprocal sum; a sum that is not positive forces the hot limit
  // ---------------------------------------------------------------------------
  logic [INV_W-1:0] inv_s;
  logic             nonpos;
  logic [INV_W-1:0] den_fin_r;
  logic             nonpos_r;

  assign inv_s  = lneg_sh_r[DIV_STAGES-1] ? INV_W'(inv0_q) - INV_W'(term_q)
                                          : INV_W'(inv0_q) + INV_W'(term_q);
  assign nonpos = inv_s[INV_W-1] || (inv_s == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      den_fin_r <= nonpos ? INV_W'(1) : inv_s;
      nonpos_r  <= nonpos;
    end
  end

  // ---------------------------------------------------------------------------
  // 10*T in Q.8
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]      t10_q;
  logic [DIV_STAGES-1:0] nonpos_sh_r;

  ntcbt_div u_div_fin (
    .clk (clk),
    .en  (adv),
    .num (DIV_W'(FIN_NUM) << FIN_SH),
    .den (DIV_W'(den_fin_r)),
    .quo (t10_q)
  );

  always_ff @(posedge clk) begin
    if (adv) nonpos_sh_r <= {nonpos_sh_r[DIV_STAGES-2:0], nonpos_r};
  end

  // ---------------------------------------------------------------------------
  // Subtract 273.15 K (in tenths, Q.8), truncate toward zero, saturate
  // ---------------------------------------------------------------------------
  logic [V_W-1:0]       v_r;
  logic                 nonpos_p_r;
  logic                 v_neg;
  logic [V_W-1:0]       v_abs;
  logic [V_W-Q8_SH-1:0] v_int;
  logic signed [TEMP_W-1:0] temp_nxt, out_temp_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r        <= V_W'(t10_q) - V_W'(OFFSET_Q8);
      nonpos_p_r <= nonpos_sh_r[DIV_STAGES-1];
    end
  end

  assign v_neg = v_r[V_W-1];
  assign v_abs = v_neg ? (~v_r + V_W'(1)) : v_r;
  assign v_int = v_abs[V_W-1:Q8_SH];

  always_comb begin
    if (nonpos_p_r) begin
      temp_nxt = OUT_MAX;
    end else if (!v_neg) begin
      if (v_int > (V_W-Q8_SH)'(OUT_HI_MAG)) temp_nxt = OUT_MAX;
      else temp_nxt = $signed(v_int[TEMP_W-1:0]);
    end else begin
      if (v_int > (V_W-Q8_SH)'(OUT_LO_MAG)) temp_nxt = OUT_MIN;
      else temp_nxt = $signed(TEMP_W'(0) - v_int[TEMP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) out_temp_r <= temp_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.temp_tenths_c = out_temp_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Back-pressure only when a result waits and the last stage holds a request.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_valid_r && v_last))
    else $error("input stalled without a blocked result");

  // A delivered temperature is always inside the saturation range.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_temp_r <= OUT_MAX && out_temp_r >= OUT_MIN))
    else $error("temperature outside saturation range");

  // A request leaving the pipe always lands in the output register.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v_last && out_en) |=> out_valid_r)
    else $error("finished request lost at output");

  // A non-positive reciprocal sum gives the hot limit.
  a_hot_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (v_last && out_en && nonpos_p_r) |=> (out_temp_r == OUT_MAX))
    else $error("non-positive reciprocal sum not forced to hot limit");

  // A stalled pipe keeps its occupancy.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(vld_r) && out_valid_r))
    else $error("pipeline occupancy changed during stall");

endmodule
